@@ design/pctb_pkg.sv @@
// shared constants, codes and control structs for the paired counter threshold bank
// no dependencies; used by every other file of the block but pctb_ram
`default_nettype none

package pctb_pkg;

  // bank geometry
  localparam int PAIRS       = 32;
  localparam int COUNT_WIDTH = 32;
  localparam int PAIR_W      = 2 * COUNT_WIDTH;
  localparam int PAIR_AW     = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int SUM_W       = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;

  // field widths
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 6;
  localparam int PIU_W     = 6;
  localparam int SET_W     = 6;
  localparam int STHR_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_INC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVAL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAIRS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_THR = 2'd2;

  // register reset values
  localparam logic [PIU_W-1:0]  PIU_RESET      = 6'd32;
  localparam logic [SET_W-1:0]  SET_THR_RESET  = 6'd1;
  localparam logic [STHR_W-1:0] SUM_THR_RESET  = 32'd1;

  // controller to datapath
  typedef struct packed {
    logic latch_item;   // capture the accepted item
    logic rd_item;      // read the pair named by the incoming index
    logic walk_start;   // reset walk pointer and accumulators
    logic walk_step;    // advance the evaluation walk
    logic inc_commit;   // write back the incremented pair
    logic clear_store;  // drop every pair to zero
    logic res_load;     // move the result into the output register
  } pctb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] in_kind;
    logic              walk_done;
    logic              out_free;
  } pctb_status_t;

endpackage

`default_nettype wire

@@ design/pctb_if.sv @@
// item, result and configuration channel interfaces
// depends on pctb_pkg for field widths
`default_nettype none

interface pctb_item_if;
  logic                        valid;
  logic                        ready;
  logic [pctb_pkg::KIND_W-1:0] kind;
  logic [pctb_pkg::IDX_W-1:0]  counter_index;

  modport source (output valid, output kind, output counter_index, input ready);
  modport sink   (input valid, input kind, input counter_index, output ready);
endinterface

interface pctb_result_if;
  logic valid;
  logic ready;
  logic index_error;
  logic set_met;
  logic sum_met;
  logic combined_met;
  logic has_info;

  modport source (output valid, output index_error, output set_met, output sum_met,
                  output combined_met, output has_info, input ready);
  modport sink   (input valid, input index_error, input set_met, input sum_met,
                  input combined_met, input has_info, output ready);
endinterface

interface pctb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pctb_pkg::CFG_IDX_W-1:0] index;
  logic [pctb_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/pctb_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module pctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/pctb_dp.sv @@
// datapath: config registers, pair store with valid bits, increment and walk logic
// depends on pctb_pkg, pctb_if and pctb_ram
`default_nettype none

module pctb_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [pctb_pkg::KIND_W-1:0] in_kind,
  input  wire logic [pctb_pkg::IDX_W-1:0]  in_index,
  input  wire pctb_pkg::pctb_cmd_t         cmd,
  output pctb_pkg::pctb_status_t           status,
  pctb_cfg_if.sink                         cfg,
  pctb_result_if.source                    result
);

  localparam int CW = pctb_pkg::COUNT_WIDTH;
  localparam int AW = pctb_pkg::PAIR_AW;
  localparam int SW = pctb_pkg::SUM_W;

  // configuration
  logic [pctb_pkg::PIU_W-1:0]  pairs_in_use;
  logic [pctb_pkg::SET_W-1:0]  set_thr;
  logic [pctb_pkg::STHR_W-1:0] sum_thr;
  logic                        cfg_wr;

  // latched item
  logic [pctb_pkg::KIND_W-1:0] kind_q;
  logic [pctb_pkg::IDX_W-1:0]  idx_q;

  // store
  logic [pctb_pkg::PAIRS-1:0]  pair_valid;
  logic                        rd_vld;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [AW-1:0]               ram_waddr;
  logic [pctb_pkg::PAIR_W-1:0] ram_rdata;
  logic [pctb_pkg::PAIR_W-1:0] ram_wdata;
  logic                        ram_we;
  logic                        store_clear;

  logic [CW-1:0] cnt_lo;
  logic [CW-1:0] cnt_hi;
  logic [CW-1:0] cur;
  logic [CW-1:0] bumped;

  logic [pctb_pkg::PIU_W-1:0] np;
  logic [pctb_pkg::PIU_W-1:0] thr;
  logic                       inc_err;
  logic                       info;
  logic                       info_next;

  // walk
  logic [pctb_pkg::PIU_W-1:0] ptr;
  logic                       rd_pending;
  logic                       walk_more;
  logic [pctb_pkg::PIU_W-1:0] nz_cnt;
  logic [pctb_pkg::PIU_W-1:0] rc_cnt;
  logic                       all_q;
  logic [SW-1:0]              a_x;
  logic [SW-1:0]              b_x;
  logic [SW-1:0]              t_x;
  logic [SW-1:0]              pair_sum;
  logic                       pair_nz;
  logic                       pair_reach;
  logic                       both_reach;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_in_use <= pctb_pkg::PIU_RESET;
      set_thr      <= pctb_pkg::SET_THR_RESET;
      sum_thr      <= pctb_pkg::SUM_THR_RESET;
    end else if (cfg_wr) begin
      case (cfg.index)
        pctb_pkg::REG_PAIRS:   pairs_in_use <= cfg.data[pctb_pkg::PIU_W-1:0];
        pctb_pkg::REG_SET_THR: set_thr      <= cfg.data[pctb_pkg::SET_W-1:0];
        pctb_pkg::REG_SUM_THR: sum_thr      <= cfg.data[pctb_pkg::STHR_W-1:0];
        default: ;
      endcase
    end
  end

  // active pairs and clamped set threshold
  assign np  = (int'(pairs_in_use) > pctb_pkg::PAIRS) ? pctb_pkg::PIU_W'(pctb_pkg::PAIRS)
                                                      : pairs_in_use;
  assign thr = (set_thr > np) ? np : set_thr;

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      kind_q <= in_kind;
      idx_q  <= in_index;
    end
  end

  assign status.in_kind = in_kind;

  // store access
  assign walk_more = ptr < np;
  assign ram_re    = cmd.rd_item || (cmd.walk_step && walk_more);
  assign ram_raddr = cmd.rd_item ? AW'(in_index >> 1) : AW'(ptr);
  assign ram_waddr = AW'(idx_q >> 1);

  assign inc_err = {1'b0, idx_q} >= {np, 1'b0};
  assign ram_we  = cmd.inc_commit && !inc_err;

  assign cnt_lo = rd_vld ? ram_rdata[CW-1:0]    : '0;
  assign cnt_hi = rd_vld ? ram_rdata[2*CW-1:CW] : '0;

  // saturating increment of the selected half
  assign cur       = idx_q[0] ? cnt_hi : cnt_lo;
  assign bumped    = (cur == pctb_pkg::CNT_MAX) ? cur : cur + CW'(1);
  assign ram_wdata = idx_q[0] ? {bumped, cnt_lo} : {cnt_hi, bumped};

  pctb_ram #(
    .WIDTH (pctb_pkg::PAIR_W),
    .DEPTH (pctb_pkg::PAIRS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // pairs never written since the last clear read as zero
  assign store_clear = cmd.clear_store || (cfg_wr && cfg.index == pctb_pkg::REG_PAIRS);

  always_ff @(posedge clk) begin
    if (rst || store_clear) begin
      pair_valid <= '0;
    end else if (ram_we) begin
      pair_valid[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld <= pair_valid[ram_raddr];
    end
  end

  // info flag
  assign info_next = info || (cmd.inc_commit && !inc_err);

  always_ff @(posedge clk) begin
    if (rst) begin
      info <= 1'b0;
    end else begin
      info <= info_next;
    end
  end

  // per pair evaluation
  assign a_x        = SW'(cnt_lo);
  assign b_x        = SW'(cnt_hi);
  assign t_x        = SW'(sum_thr);
  assign pair_sum   = a_x + b_x;
  assign pair_nz    = (cnt_lo != '0) || (cnt_hi != '0);
  assign pair_reach = pair_sum >= t_x;
  assign both_reach = (a_x >= t_x) && (b_x >= t_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else if (cmd.walk_start) begin
      rd_pending <= 1'b0;
    end else if (cmd.walk_step) begin
      rd_pending <= walk_more;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      ptr    <= '0;
      nz_cnt <= '0;
      rc_cnt <= '0;
      all_q  <= 1'b1;
    end else if (cmd.walk_step) begin
      if (walk_more) begin
        ptr <= ptr + pctb_pkg::PIU_W'(1);
      end
      if (rd_pending) begin
        nz_cnt <= nz_cnt + {{(pctb_pkg::PIU_W-1){1'b0}}, pair_nz};
        rc_cnt <= rc_cnt + {{(pctb_pkg::PIU_W-1){1'b0}}, pair_reach};
        all_q  <= all_q && both_reach;
      end
    end
  end

  assign status.walk_done = !walk_more && !rd_pending;

  // output register
  assign status.out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.res_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.index_error  <= (kind_q == pctb_pkg::KIND_INC) && inc_err;
      result.set_met      <= (kind_q == pctb_pkg::KIND_EVAL) && (nz_cnt >= thr);
      result.sum_met      <= (kind_q == pctb_pkg::KIND_EVAL) && all_q;
      result.combined_met <= (kind_q == pctb_pkg::KIND_EVAL) && (rc_cnt >= thr);
      result.has_info     <= info_next;
    end
  end

endmodule

`default_nettype wire

@@ design/pctb_ctrl.sv @@
// controller state machine sequencing increments, walks and result hand-off
// depends on pctb_pkg
`default_nettype none

module pctb_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire pctb_pkg::pctb_status_t status,
  output pctb_pkg::pctb_cmd_t         cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INC  = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.latch_item = 1'b1;
          case (status.in_kind)
            pctb_pkg::KIND_INC: begin
              cmd.rd_item = 1'b1;
              state_next  = S_INC;
            end
            pctb_pkg::KIND_EVAL: begin
              cmd.walk_start = 1'b1;
              state_next     = S_EVAL;
            end
            pctb_pkg::KIND_CLEAR: begin
              cmd.clear_store = 1'b1;
              state_next      = S_FIN;
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_INC: begin
        // read data holds until the output register frees
        if (status.out_free) begin
          cmd.inc_commit = 1'b1;
          cmd.res_load   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_EVAL: begin
        cmd.walk_step = 1'b1;
        if (status.walk_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> status.out_free)
    else $error("result loaded while output register still full");

  a_commit_with_result: assert property (@(posedge clk) disable iff (rst)
    cmd.inc_commit |-> cmd.res_load)
    else $error("increment written back without its result");

  a_inc_goes_to_rmw: assert property (@(posedge clk) disable iff (rst)
    (accept && status.in_kind == pctb_pkg::KIND_INC) |=> (state == S_INC && !in_ready))
    else $error("increment item did not enter read-modify-write");

  a_walk_ends_in_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && status.walk_done) |=> (state == S_FIN))
    else $error("finished walk did not move to result stage");
`endif

endmodule

`default_nettype wire

@@ design/paired_counter_threshold_bank.sv @@
// top level of the paired counter threshold bank
// depends on pctb_pkg, pctb_if, pctb_ctrl and pctb_dp
`default_nettype none

//  channel  | direction | handshake      | payload
//  ---------+-----------+----------------+------------------------------------------
//  item     | in        | valid / ready  | kind, counter_index
//  result   | out       | valid / ready  | index_error, set_met, sum_met,
//           |           |                | combined_met, has_info
//  cfg      | in        | valid / ready  | index (register), data
//
//  increment reads the pair from the ram, then writes it back and loads the
//  output register once that register is free
//  evaluate makes one ram read per pair in use, folds in the last pair if any,
//  sees the walk done, then loads the output register once it is free
//  reset is synchronous; the store starts zeroed through per pair valid bits,
//  so no clearing pass is needed and clear items need no walk
//  a stalled result holds in the output register; the next item is taken
//  meanwhile and waits in its last step until the register frees

module paired_counter_threshold_bank (
  input  wire logic     clk,
  input  wire logic     rst,
  pctb_item_if.sink     item,
  pctb_result_if.source result,
  pctb_cfg_if.sink      cfg
);

  pctb_pkg::pctb_cmd_t    cmd;
  pctb_pkg::pctb_status_t status;
  logic                   in_ready;

  assign item.ready = in_ready;

  // sequencing: one item at a time
  pctb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // registers, pair store, increment and evaluation walk, output register
  pctb_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_kind  (item.kind),
    .in_index (item.counter_index),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg),
    .result   (result)
  );

endmodule

`default_nettype wire

@@ tb/sv/paired_counter_threshold_bank_tb.sv @@
// self-checking testbench for the paired counter threshold bank
// depends on pctb_pkg, pctb_if and the paired_counter_threshold_bank rtl
`default_nettype none

module paired_counter_threshold_bank_tb;
  import pctb_pkg::*;

  // codes the package leaves unnamed: the spare item kind and register slot
  localparam logic [KIND_W-1:0]    KIND_NONE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off, in cycles
  localparam int unsigned RANDOM_ITEMS = 78;    // random items per phase, beside its opening evaluate
  localparam int unsigned PHASES       = 10;

  // one result item as the checker sees it
  typedef struct packed {
    logic index_error;
    logic set_met;
    logic sum_met;
    logic combined_met;
    logic has_info;
  } flags_t;

  // mirror of the counter bank plus the queue of results still owed
  class tally_checker;
    logic [COUNT_WIDTH-1:0] bank [2*PAIRS];
    logic                   info_seen;
    logic [PIU_W-1:0]       pairs_in_use;
    logic [SET_W-1:0]       set_thr;
    logic [STHR_W-1:0]      sum_thr;
    flags_t                 flags_due [$];
    int unsigned            errors;

    function new();
      foreach (bank[i]) bank[i] = '0;
      info_seen    = 1'b0;
      pairs_in_use = PIU_RESET;
      set_thr      = SET_THR_RESET;
      sum_thr      = SUM_THR_RESET;
      errors       = 0;
    endfunction

    function int unsigned live_pairs();
      return (int'(pairs_in_use) > PAIRS) ? PAIRS : pairs_in_use;
    endfunction

    function int unsigned pending();
      return flags_due.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_PAIRS: begin
          // resizing the bank drops every count, the info flag survives
          pairs_in_use = data[PIU_W-1:0];
          foreach (bank[i]) bank[i] = '0;
        end
        REG_SET_THR: set_thr = data[SET_W-1:0];
        REG_SUM_THR: sum_thr = data[STHR_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the mirror by one item and return the flags it should produce
    function flags_t predict_flags(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx);
      flags_t                 f;
      int unsigned            np, thr, nonzero, reached, p;
      bit                     all_reach;
      logic [COUNT_WIDTH-1:0] a, b;
      logic [COUNT_WIDTH:0]   pair_sum;
      f  = '0;
      np = live_pairs();
      case (kind)
        KIND_INC: begin
          if (idx >= 2 * np) begin
            f.index_error = 1'b1;
          end else begin
            if (bank[idx] != CNT_MAX) bank[idx] = bank[idx] + 1'b1;
            info_seen = 1'b1;
          end
        end
        KIND_EVAL: begin
          thr       = (set_thr > np) ? np : set_thr;
          nonzero   = 0;
          reached   = 0;
          all_reach = 1'b1;
          for (p = 0; p < np; p++) begin
            a        = bank[2*p];
            b        = bank[2*p+1];
            pair_sum = a + b;
            if (a != 0 || b != 0) nonzero++;
            if (a < sum_thr || b < sum_thr) all_reach = 1'b0;
            if (pair_sum >= sum_thr) reached++;
          end
          f.set_met      = (nonzero >= thr);
          f.sum_met      = all_reach;
          f.combined_met = (reached >= thr);
        end
        KIND_CLEAR: foreach (bank[i]) bank[i] = '0;
        default: ;
      endcase
      f.has_info = info_seen;
      return f;
    endfunction

    function void take_item(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx);
      flags_due = {flags_due, predict_flags(kind, idx)};
    endfunction

    function void note_failure(string what, flags_t want, flags_t got);
      errors++;
      if (errors <= 10)
        $display("%s: expected err=%b set=%b sum=%b comb=%b info=%b, got err=%b set=%b sum=%b comb=%b info=%b",
                 what, want.index_error, want.set_met, want.sum_met, want.combined_met,
                 want.has_info, got.index_error, got.set_met, got.sum_met,
                 got.combined_met, got.has_info);
    endfunction

    function void check_flags(flags_t got);
      flags_t want;
      if (flags_due.size() == 0) begin
        note_failure("result with nothing outstanding", '0, got);
        return;
      end
      want = flags_due.pop_front();
      if (got.index_error !== want.index_error || got.set_met !== want.set_met ||
          got.sum_met !== want.sum_met || got.combined_met !== want.combined_met ||
          got.has_info !== want.has_info)
        note_failure("result mismatch", want, got);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   hold_request;   // raised by the stimulus, served by the receiver

  pctb_item_if   item_ch ();
  pctb_result_if res_ch ();
  pctb_cfg_if    cfg_ch ();

  tally_checker sb;

  paired_counter_threshold_bank uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // everything that crosses a handshake is sampled here, at the edge itself
  always @(posedge clk) begin : watch
    flags_t got;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_reg(cfg_ch.index, cfg_ch.data);
      if (item_ch.valid && item_ch.ready) sb.take_item(item_ch.kind, item_ch.counter_index);
      if (res_ch.valid && res_ch.ready) begin
        got.index_error  = res_ch.index_error;
        got.set_met      = res_ch.set_met;
        got.sum_met      = res_ch.sum_met;
        got.combined_met = res_ch.combined_met;
        got.has_info     = res_ch.has_info;
        sb.check_flags(got);
      end
    end
  end

  // result side backpressure: the stall pattern is redrawn at random, and a
  // long hold-off on request lets the block fill up behind it
  initial begin : receiver
    int unsigned cyc, mode;
    cyc  = 0;
    mode = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      if (hold_request) begin
        hold_request = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case (mode)
          0: res_ch.ready <= 1'b1;                          // no stalls
          1: res_ch.ready <= 1'($urandom_range(0, 1));      // coin flip
          2: res_ch.ready <= (cyc % 4 == 0);                // one in four
          default: res_ch.ready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // register value with random upper bits that the block must ignore
  function automatic logic [CFG_DAT_W-1:0] noisy_reg(int unsigned v);
    logic [CFG_DAT_W-1:0] d;
    d = $urandom();
    d[PIU_W-1:0] = PIU_W'(v);
    return d;
  endfunction

  // valid stays high on return so a burst can go on without a bubble
  task automatic offer_item(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] ix);
    item_ch.valid         <= 1'b1;
    item_ch.kind          <= k;
    item_ch.counter_index <= ix;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic item_gap(input int unsigned n);
    item_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic drain_items();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic cfg_release();
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // new settings for a random phase; each register may keep its old value
  task automatic random_setup();
    int unsigned          r;
    logic [CFG_DAT_W-1:0] d;
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      if (r < 40)      d = noisy_reg($urandom_range(1, 4));
      else if (r < 65) d = noisy_reg($urandom_range(5, 31));
      else if (r < 75) d = noisy_reg(32);
      else if (r < 85) d = noisy_reg(0);
      else             d = noisy_reg($urandom_range(33, 63));
      write_reg(REG_PAIRS, d);
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 99);
      if (r < 60)      d = noisy_reg($urandom_range(0, 4));
      else if (r < 75) d = noisy_reg(63);
      else if (r < 85) d = noisy_reg(0);
      else             d = noisy_reg($urandom_range(0, 63));
      write_reg(REG_SET_THR, d);
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 99);
      if (r < 50)      d = $urandom_range(0, 8);
      else if (r < 60) d = '0;
      else if (r < 70) d = $urandom();
      else if (r < 80) d = '1;
      else             d = $urandom_range(9, 40);
      write_reg(REG_SUM_THR, d);
    end
    if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom());
    cfg_release();
  endtask

  // mostly increments on counters in use so pairs fill up and thresholds
  // get crossed; evaluates sprinkled in, few clears, some stray indexes and spare kinds
  task automatic random_phase(input int unsigned n, input bit steady);
    int unsigned       burst_left, r, np;
    logic [KIND_W-1:0] k;
    logic [IDX_W-1:0]  ix;
    burst_left = $urandom_range(1, 16);
    // first look right after the settings change, before any new count
    offer_item(KIND_EVAL, IDX_W'($urandom_range(0, 63)));
    repeat (n) begin
      np = sb.live_pairs();
      r  = $urandom_range(0, 99);
      ix = IDX_W'($urandom_range(0, 63));
      if (r < 75) begin
        k = KIND_INC;
        if (np != 0) ix = IDX_W'($urandom_range(0, 2 * np - 1));
      end else if (r < 80) begin
        k = KIND_INC;
      end else if (r < 93) begin
        k = KIND_EVAL;
      end else if (r < 95) begin
        k = KIND_CLEAR;
      end else begin
        k = KIND_NONE;
      end
      offer_item(k, ix);
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 16);
        if (!steady) item_gap($urandom_range(1, 6));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    sb = new();
    hold_request           = 1'b0;
    rst                   <= 1'b1;
    item_ch.valid         <= 1'b0;
    item_ch.kind          <= KIND_INC;
    item_ch.counter_index <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_PAIRS;
    cfg_ch.data           <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // power-on settings, nothing counted yet: info flag still low
    offer_item(KIND_EVAL, '0);
    offer_item(KIND_NONE, '1);
    offer_item(KIND_CLEAR, '0);
    drain_items();

    // no pairs in use: every increment is out of range, evaluate sees nothing
    write_reg(REG_PAIRS, noisy_reg(0));
    cfg_release();
    offer_item(KIND_INC, 6'd5);
    offer_item(KIND_INC, '0);
    offer_item(KIND_EVAL, '0);
    drain_items();

    // single pair with zero thresholds, then its edges and out of range
    write_reg(REG_PAIRS, noisy_reg(1));
    write_reg(REG_SET_THR, noisy_reg(0));
    write_reg(REG_SUM_THR, '0);
    cfg_release();
    offer_item(KIND_EVAL, '0);
    offer_item(KIND_INC, 6'd0);
    offer_item(KIND_INC, 6'd1);
    offer_item(KIND_INC, 6'd2);
    offer_item(KIND_INC, '1);
    offer_item(KIND_EVAL, '0);
    offer_item(KIND_CLEAR, '1);
    offer_item(KIND_EVAL, '0);
    drain_items();

    // more pairs than the bank holds, set threshold clamped, top sum threshold
    write_reg(REG_PAIRS, noisy_reg(63));
    write_reg(REG_SET_THR, noisy_reg(63));
    write_reg(REG_SUM_THR, '1);
    write_reg(REG_UNUSED, $urandom());
    cfg_release();
    offer_item(KIND_INC, '1);
    offer_item(KIND_INC, 6'd62);
    offer_item(KIND_INC, 6'd0);
    offer_item(KIND_EVAL, '0);
    offer_item(KIND_NONE, '0);
    drain_items();

    // back to the full bank with the power-on thresholds
    write_reg(REG_PAIRS, noisy_reg(32));
    write_reg(REG_SET_THR, noisy_reg(1));
    write_reg(REG_SUM_THR, 32'd1);
    cfg_release();
    offer_item(KIND_INC, 6'd10);
    offer_item(KIND_EVAL, '0);

    // random phases; one holds the receiver off while items keep coming,
    // two run the sender without gaps
    for (phase = 0; phase < PHASES; phase++) begin
      drain_items();
      random_setup();
      if (phase == 2) hold_request = 1'b1;
      random_phase(RANDOM_ITEMS, phase == 2 || phase == 5);
    end

    drain_items();
    // room for a stray result after the last walk would have ended
    repeat (PAIRS + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
